// ===== hdl/olt_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list table engine package
// Shared widths, operation and status codes, and the structs that pass
// between the control logic, the entry cells and the group reducers.
// ----------------------------------------------------------------------------
package olt_pkg;

    // Field widths of one item and one result.
    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    // Cells are reduced in groups of eight.
    localparam int GROUP = 8;
    localparam int OFF_W = 3;

    // Configuration register map.
    localparam int ADDR_W       = 3;
    localparam int REG_CAPACITY = 0;
    localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_LOCATE = 2'd2,
        FN_GET    = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command broadcast along the row of cells.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  pos_m1;
        logic [CNT_W-1:0]  count;
        logic              cmp_en;
        logic              ins_en;
        logic              del_en;
    } cell_cmd_t;

    // Registered summary of one group of cells.
    typedef struct packed {
        logic              any_match;
        logic [OFF_W-1:0]  first_off;
        logic [DATA_W-1:0] sel_data;
    } grp_res_t;

endpackage

// ===== hdl/olt_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered list entry cell
// Holds one list entry. Shifts in from its left or right neighbour on
// insert and delete, and registers its own compare and position hits.
// ----------------------------------------------------------------------------
module olt_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  olt_pkg::cell_cmd_t            cmd,
    input  logic [olt_pkg::DATA_W-1:0]    left_entry,
    input  logic [olt_pkg::DATA_W-1:0]    right_entry,
    output logic [olt_pkg::DATA_W-1:0]    entry,
    output logic                          match,
    output logic                          sel
);

    logic [olt_pkg::DATA_W-1:0] entry_reg;
    logic [olt_pkg::DATA_W-1:0] entry_next;
    logic                       match_reg;
    logic                       match_next;
    logic                       sel_reg;
    logic                       sel_next;
    logic                       at_pos;
    logic                       above_pos;
    logic                       in_list;

    // Position of this cell relative to the request.
    assign at_pos    = (IDX == int'(cmd.pos_m1));
    assign above_pos = (IDX >  int'(cmd.pos_m1));
    assign in_list   = (IDX <  int'(cmd.count));

    // Compare against the requested value and position.
    always_comb
    begin
        match_next = match_reg;
        sel_next   = sel_reg;
        if (cmd.cmp_en)
        begin
            match_next = in_list && (entry_reg == cmd.value);
            sel_next   = at_pos;
        end
    end

    // Shift the entry on insert or delete.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_en)
        begin
            if (at_pos)
            begin
                entry_next = cmd.value;
            end
            else if (above_pos)
            begin
                entry_next = left_entry;
            end
        end
        else if (cmd.del_en)
        begin
            if (at_pos || above_pos)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            sel_reg   <= sel_next;
        end
    end

    // Entry payload carries no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;
    assign sel   = sel_reg;

endmodule

// ===== hdl/olt_group.sv =====
// ----------------------------------------------------------------------------
// Ordered list group reducer
// Summarises a group of eight cells into a registered first-match offset,
// a match flag and the entry of the cell at the requested position.
// ----------------------------------------------------------------------------
module olt_group (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic [olt_pkg::GROUP-1:0]                  match,
    input  logic [olt_pkg::GROUP-1:0]                  sel,
    input  logic [olt_pkg::GROUP-1:0][olt_pkg::DATA_W-1:0] entry,
    output olt_pkg::grp_res_t                          res
);

    olt_pkg::grp_res_t res_reg;
    olt_pkg::grp_res_t res_next;

    // Lowest matching cell wins; at most one cell is selected.
    always_comb
    begin
        res_next.any_match = |match;
        res_next.first_off = '0;
        res_next.sel_data  = '0;
        for (int k = olt_pkg::GROUP - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                res_next.first_off = olt_pkg::OFF_W'(k);
            end
        end
        for (int k = 0; k < olt_pkg::GROUP; k++)
        begin
            if (sel[k])
            begin
                res_next.sel_data = res_next.sel_data | entry[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== hdl/ordered_list_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// Ordered list table engine
// Bounded ordered list of signed 32-bit values held in a row of entry cells,
// with insert, delete, locate and get requests and a capacity register.
//
//   Port group   Direction  Handshake            Payload
//   in           input      in_valid/in_ready    func, position, value
//   out          output     out_valid/out_ready  status, data, found_index,
//                                                length
//   apb          input      psel/penable/pready  paddr, pwdata, prdata
//
// From acceptance to its result being presented, each item is compared in the
// cells, reduced in the group reducers, and then the first group is picked
// and the shift committed. The next item is accepted in the cycle after the
// commit, even while the previous result still waits in the output register,
// so a new item is not taken before the last one is committed. A result that
// is not taken holds the commit back. No clearing pass is needed after reset;
// the list starts empty.
// ----------------------------------------------------------------------------
module ordered_list_table_engine_core #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [olt_pkg::FUNC_W-1:0]    func,
    input  logic [olt_pkg::CNT_W-1:0]     position,
    input  logic signed [olt_pkg::DATA_W-1:0] value,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [olt_pkg::STAT_W-1:0]    status,
    output logic signed [olt_pkg::DATA_W-1:0] data,
    output logic [olt_pkg::CNT_W-1:0]     found_index,
    output logic [olt_pkg::CNT_W-1:0]     length,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [olt_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int NUM_GRP  = (STORE_DEPTH + olt_pkg::GROUP - 1) / olt_pkg::GROUP;
    localparam int NUM_SLOT = NUM_GRP * olt_pkg::GROUP;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_GRP,
        S_FIN
    } state_t;

    state_t                          state_reg;
    olt_pkg::func_t                  func_reg;
    logic [olt_pkg::CNT_W-1:0]       pos_reg;
    logic [olt_pkg::DATA_W-1:0]      value_reg;
    logic [olt_pkg::CNT_W-1:0]       count_reg;
    logic [olt_pkg::CNT_W-1:0]       count_next;
    logic [olt_pkg::CNT_W-1:0]       capacity_reg;
    olt_pkg::status_t                stat_reg;
    olt_pkg::status_t                stat_next;
    logic                            out_valid_reg;
    logic [olt_pkg::STAT_W-1:0]      status_reg;
    logic [olt_pkg::DATA_W-1:0]      data_reg;
    logic [olt_pkg::CNT_W-1:0]       found_reg;
    logic [olt_pkg::CNT_W-1:0]       length_reg;

    logic                            accept;
    logic                            commit;
    logic                            cfg_write;
    olt_pkg::cell_cmd_t              cmd;
    logic [NUM_SLOT-1:0]             match_arr;
    logic [NUM_SLOT-1:0]             sel_arr;
    logic [NUM_SLOT-1:0][olt_pkg::DATA_W-1:0] entry_arr;
    olt_pkg::grp_res_t               grp_res [NUM_GRP];
    logic [olt_pkg::CNT_W-1:0]       found_c;
    logic [olt_pkg::DATA_W-1:0]      sel_data_c;
    int                              eff_cap;

    // Handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign commit    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (int'(paddr[olt_pkg::ADDR_W-1:2]) == olt_pkg::REG_CAPACITY)
                    ? {{(32 - olt_pkg::CNT_W){1'b0}}, capacity_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= olt_pkg::CAPACITY_RESET;
        end
        else if (cfg_write &&
                 (int'(paddr[olt_pkg::ADDR_W-1:2]) == olt_pkg::REG_CAPACITY))
        begin
            capacity_reg <= pwdata[olt_pkg::CNT_W-1:0];
        end
    end

    // Status of the request, worked out from the count before it.
    assign eff_cap = (int'(capacity_reg) < STORE_DEPTH) ? int'(capacity_reg) : STORE_DEPTH;

    always_comb
    begin
        stat_next = olt_pkg::ST_OK;
        unique case (func_reg)
            olt_pkg::FN_INSERT:
            begin
                if ((pos_reg == '0) || (int'(pos_reg) > int'(count_reg) + 1))
                begin
                    stat_next = olt_pkg::ST_RANGE;
                end
                else if (int'(count_reg) >= eff_cap)
                begin
                    stat_next = olt_pkg::ST_FULL;
                end
            end
            olt_pkg::FN_DELETE, olt_pkg::FN_GET:
            begin
                if ((pos_reg == '0) || (pos_reg > count_reg))
                begin
                    stat_next = olt_pkg::ST_RANGE;
                end
            end
            olt_pkg::FN_LOCATE:
            begin
                stat_next = olt_pkg::ST_OK;
            end
        endcase
    end

    // Command broadcast to the cells
    always_comb
    begin
        cmd.value  = value_reg;
        cmd.pos_m1 = pos_reg - olt_pkg::CNT_W'(1);
        cmd.count  = count_reg;
        cmd.cmp_en = (state_reg == S_CMP);
        cmd.ins_en = commit && (func_reg == olt_pkg::FN_INSERT) && (stat_reg == olt_pkg::ST_OK);
        cmd.del_en = commit && (func_reg == olt_pkg::FN_DELETE) && (stat_reg == olt_pkg::ST_OK);
    end

    // Row of entry cells; slots past the store depth read as empty.
    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOT; gi++)
        begin : g_slot
            if (gi < STORE_DEPTH)
            begin : g_cell
                logic [olt_pkg::DATA_W-1:0] left_w;
                logic [olt_pkg::DATA_W-1:0] right_w;
                if (gi == 0)
                begin : g_first
                    assign left_w = '0;
                end
                else
                begin : g_mid_l
                    assign left_w = entry_arr[gi-1];
                end
                if (gi == STORE_DEPTH - 1)
                begin : g_last
                    assign right_w = '0;
                end
                else
                begin : g_mid_r
                    assign right_w = entry_arr[gi+1];
                end
                olt_cell #(
                    .IDX (gi)
                ) u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .cmd         (cmd),
                    .left_entry  (left_w),
                    .right_entry (right_w),
                    .entry       (entry_arr[gi]),
                    .match       (match_arr[gi]),
                    .sel         (sel_arr[gi])
                );
            end
            else
            begin : g_pad
                assign entry_arr[gi] = '0;
                assign match_arr[gi] = 1'b0;
                assign sel_arr[gi]   = 1'b0;
            end
        end

        for (gi = 0; gi < NUM_GRP; gi++)
        begin : g_grp
            olt_group u_group (
                .clk   (clk),
                .rst_n (rst_n),
                .match (match_arr[gi*olt_pkg::GROUP +: olt_pkg::GROUP]),
                .sel   (sel_arr[gi*olt_pkg::GROUP +: olt_pkg::GROUP]),
                .entry (entry_arr[gi*olt_pkg::GROUP +: olt_pkg::GROUP]),
                .res   (grp_res[gi])
            );
        end
    endgenerate

    // Pick the first matching group and gather the selected entry.
    always_comb
    begin
        found_c    = '0;
        sel_data_c = '0;
        for (int g = NUM_GRP - 1; g >= 0; g--)
        begin
            if (grp_res[g].any_match)
            begin
                found_c = olt_pkg::CNT_W'(g * olt_pkg::GROUP + int'(grp_res[g].first_off) + 1);
            end
        end
        for (int g = 0; g < NUM_GRP; g++)
        begin
            sel_data_c = sel_data_c | grp_res[g].sel_data;
        end
    end

    // Count after the request
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins_en)
        begin
            count_next = count_reg + olt_pkg::CNT_W'(1);
        end
        else if (cmd.del_en)
        begin
            count_next = count_reg - olt_pkg::CNT_W'(1);
        end
    end

    // Sequencer, list count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            stat_reg      <= olt_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            // A new result replaces one that leaves at the same edge.
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    stat_reg  <= stat_next;
                    state_reg <= S_GRP;
                end
                S_GRP:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (commit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Item and result payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= olt_pkg::func_t'(func);
            pos_reg   <= position;
            value_reg <= value;
        end
        if (commit)
        begin
            status_reg <= stat_reg;
            length_reg <= count_next;
            found_reg  <= (func_reg == olt_pkg::FN_LOCATE) ? found_c : '0;
            data_reg   <= ((stat_reg == olt_pkg::ST_OK) &&
                           ((func_reg == olt_pkg::FN_DELETE) || (func_reg == olt_pkg::FN_GET)))
                          ? sel_data_c : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign data        = data_reg;
    assign found_index = found_reg;
    assign length      = length_reg;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Ordered list table engine testbench
// Drives insert, delete, locate and get requests through the valid/ready
// request channel, predicts every result from a shadow copy of the list and
// the capacity register, and checks each result field by field. The capacity
// is rewritten over the APB port between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH      = 64;
    localparam int HOLD_LEN   = 300;
    localparam int IDLE_LIMIT = 2000;

    // One request and one response as the ports carry them.
    typedef struct {
        olt_pkg::func_t                    op;
        logic [olt_pkg::CNT_W-1:0]         pos;
        logic signed [olt_pkg::DATA_W-1:0] val;
    } list_req_t;

    typedef struct {
        olt_pkg::status_t                  status;
        logic signed [olt_pkg::DATA_W-1:0] data;
        logic [olt_pkg::CNT_W-1:0]         found;
        logic [olt_pkg::CNT_W-1:0]         length;
    } list_resp_t;

    // Contents of the list as the block should hold them.
    typedef struct {
        logic [olt_pkg::DATA_W-1:0] slot [DEPTH];
        int                         count;
    } list_image_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [olt_pkg::FUNC_W-1:0]        func = '0;
    logic [olt_pkg::CNT_W-1:0]         position = '0;
    logic signed [olt_pkg::DATA_W-1:0] value = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [olt_pkg::STAT_W-1:0]        status;
    logic signed [olt_pkg::DATA_W-1:0] data;
    logic [olt_pkg::CNT_W-1:0]         found_index;
    logic [olt_pkg::CNT_W-1:0]         length;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [olt_pkg::ADDR_W-1:0]        paddr = '0;
    logic [31:0]                       pwdata = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    list_req_t   pending_reqs [$];
    list_resp_t  expected_resps [$];
    list_image_t shadow_list;
    logic [olt_pkg::CNT_W-1:0] shadow_cap = olt_pkg::CAPACITY_RESET;
    int          errors = 0;
    bit          src_idle = 1'b0;
    bit          sink_idle = 1'b0;
    bit          hold_request = 1'b0;
    int          quiet_cycles = 0;

    ordered_list_table_engine_core #(
        .STORE_DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .data       (data),
        .found_index(found_index),
        .length     (length),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    // Applies one request to a list image and returns the response it gives.
    function automatic list_resp_t apply_request(inout list_image_t img,
                                                 input list_req_t rq,
                                                 input logic [olt_pkg::CNT_W-1:0] cap);
        list_resp_t r;
        int         room;
        int         p;
        int         j;
        r.status = olt_pkg::ST_OK;
        r.data   = '0;
        r.found  = '0;
        room     = (int'(cap) > DEPTH) ? DEPTH : int'(cap);
        p        = int'(rq.pos);
        case (rq.op)
            olt_pkg::FN_INSERT:
            begin
                // A bad position is reported even when the list is full.
                if (p < 1 || p > img.count + 1)
                    r.status = olt_pkg::ST_RANGE;
                else if (img.count >= room)
                    r.status = olt_pkg::ST_FULL;
                else
                begin
                    for (j = img.count; j >= p; j--)
                        img.slot[j] = img.slot[j-1];
                    img.slot[p-1] = rq.val;
                    img.count++;
                end
            end
            olt_pkg::FN_DELETE:
            begin
                if (p < 1 || p > img.count)
                    r.status = olt_pkg::ST_RANGE;
                else
                begin
                    r.data = img.slot[p-1];
                    for (j = p; j < img.count; j++)
                        img.slot[j-1] = img.slot[j];
                    img.count--;
                end
            end
            olt_pkg::FN_LOCATE:
            begin
                // The first matching slot wins; no match leaves the index at zero.
                for (j = 0; j < img.count; j++)
                begin
                    if (img.slot[j] == rq.val && r.found == '0)
                        r.found = olt_pkg::CNT_W'(j + 1);
                end
            end
            default:
            begin
                if (p < 1 || p > img.count)
                    r.status = olt_pkg::ST_RANGE;
                else
                    r.data = img.slot[p-1];
            end
        endcase
        r.length = olt_pkg::CNT_W'(img.count);
        return r;
    endfunction

    // Request driver: takes items from the pending queue, with random gaps while src_idle is set.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        list_req_t taken;
        list_req_t next_req;
        int        gap_left;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
            shadow_list.count = 0;
        end
        else
        begin
            // Predict the response of the item accepted at this edge.
            if (in_valid && in_ready)
            begin
                taken.op  = olt_pkg::func_t'(func);
                taken.pos = position;
                taken.val = value;
                expected_resps.push_back(apply_request(shadow_list, taken, shadow_cap));
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    next_req = pending_reqs.pop_front();
                    func     <= next_req.op;
                    position <= next_req.pos;
                    value    <= next_req.val;
                    in_valid <= 1'b1;
                    gap_left = src_idle ? $urandom_range(0, 5) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Response monitor: checks each result and throttles out_ready.
    always @(posedge clk or negedge rst_n)
    begin : response_monitor
        list_resp_t want;
        int         stall_left;
        int         hold_left;
        bit         hold_taken;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_taken = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_resps.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d data=%0d found=%0d length=%0d",
                             $time, status, data, found_index, length);
                    errors++;
                end
                else
                begin
                    want = expected_resps.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.status, status);
                        errors++;
                    end
                    if (data !== want.data)
                    begin
                        $display("%0t: data expected %0d got %0d", $time, want.data, data);
                        errors++;
                    end
                    if (found_index !== want.found)
                    begin
                        $display("%0t: found_index expected %0d got %0d",
                                 $time, want.found, found_index);
                        errors++;
                    end
                    if (length !== want.length)
                    begin
                        $display("%0t: length expected %0d got %0d", $time, want.length, length);
                        errors++;
                    end
                end
                stall_left = sink_idle ? $urandom_range(0, 5) : 0;
            end
            else if (stall_left > 0)
                stall_left = stall_left - 1;
            // A single long hold-off lets the block fill up and stall its input.
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_LEN;
            end
            else if (hold_left > 0)
                hold_left = hold_left - 1;
            out_ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // Watchdog on cycles with no transfer on any port.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic push_req(input olt_pkg::func_t op, input int pos, input logic [31:0] val);
        list_req_t rq;
        rq.op  = op;
        rq.pos = olt_pkg::CNT_W'(pos);
        rq.val = val;
        pending_reqs.push_back(rq);
    endtask

    // Waits until every item is accepted and every result has arrived.
    task automatic drain();
        @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes it at
    // the edge where psel and penable are both high.
    task automatic reg_write(input int idx, input logic [31:0] wdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= olt_pkg::ADDR_W'(idx * 4);
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == olt_pkg::REG_CAPACITY)
            shadow_cap = wdata[olt_pkg::CNT_W-1:0];
        @(negedge clk);
    endtask

    // Builds one phase of random requests, mostly at valid positions, and
    // tracks the list length as it goes so that positions stay meaningful.
    task automatic random_phase(input int n_items, input int ins_pct, input int del_pct);
        list_image_t img;
        list_req_t   rq;
        int          r;
        int          n;
        int          k;
        logic [31:0] pool [6];
        pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5};
        img  = shadow_list;
        for (k = 0; k < n_items; k++)
        begin
            n = img.count;
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                rq.op = olt_pkg::FN_INSERT;
            else if (r < ins_pct + del_pct)
                rq.op = olt_pkg::FN_DELETE;
            else
                rq.op = ($urandom_range(0, 1) != 0) ? olt_pkg::FN_LOCATE : olt_pkg::FN_GET;
            // Position: usually in range, otherwise zero, just past the end, the maximum or random.
            if ($urandom_range(0, 99) < 85)
            begin
                if (rq.op == olt_pkg::FN_INSERT)
                    rq.pos = olt_pkg::CNT_W'($urandom_range(1, n + 1));
                else
                    rq.pos = (n == 0) ? olt_pkg::CNT_W'(1)
                                      : olt_pkg::CNT_W'($urandom_range(1, n));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: rq.pos = '0;
                    1: rq.pos = olt_pkg::CNT_W'((rq.op == olt_pkg::FN_INSERT) ? n + 2 : n + 1);
                    2: rq.pos = '1;
                    default: rq.pos = olt_pkg::CNT_W'($urandom_range(0, 127));
                endcase
            end
            // Value: a few recurring values so that locate finds duplicates.
            if (rq.op == olt_pkg::FN_LOCATE && n > 0 && $urandom_range(0, 1) != 0)
                rq.val = img.slot[$urandom_range(0, n - 1)];
            else if ($urandom_range(0, 9) < 3)
                rq.val = pool[$urandom_range(0, 5)];
            else
                rq.val = $urandom;
            void'(apply_request(img, rq, shadow_cap));
            pending_reqs.push_back(rq);
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests on an empty and then a short list.
        push_req(olt_pkg::FN_GET,    1,   32'h0);
        push_req(olt_pkg::FN_DELETE, 0,   32'h0);
        push_req(olt_pkg::FN_INSERT, 0,   32'h1234);
        push_req(olt_pkg::FN_INSERT, 2,   32'h1234);
        push_req(olt_pkg::FN_INSERT, 1,   32'h7FFF_FFFF);
        push_req(olt_pkg::FN_INSERT, 1,   32'h8000_0000);
        push_req(olt_pkg::FN_INSERT, 3,   32'hFFFF_FFFF);
        push_req(olt_pkg::FN_INSERT, 2,   32'h0);
        push_req(olt_pkg::FN_INSERT, 6,   32'h7);
        push_req(olt_pkg::FN_LOCATE, 0,   32'h8000_0000);
        push_req(olt_pkg::FN_LOCATE, 127, 32'hFFFF_FFFF);
        push_req(olt_pkg::FN_LOCATE, 3,   32'd12345);
        push_req(olt_pkg::FN_GET,    4,   32'h0);
        push_req(olt_pkg::FN_GET,    5,   32'h0);
        push_req(olt_pkg::FN_GET,    127, 32'h0);
        push_req(olt_pkg::FN_DELETE, 127, 32'h0);
        push_req(olt_pkg::FN_DELETE, 4,   32'h0);
        push_req(olt_pkg::FN_DELETE, 1,   32'h0);
        push_req(olt_pkg::FN_INSERT, 3,   32'h55AA_55AA);
        push_req(olt_pkg::FN_LOCATE, 1,   32'h0);
        drain();

        // Capacity below the length: reads still work, inserts are refused.
        reg_write(olt_pkg::REG_CAPACITY, 32'd1);
        push_req(olt_pkg::FN_INSERT, 1,   32'h1);
        push_req(olt_pkg::FN_INSERT, 100, 32'h1);
        push_req(olt_pkg::FN_GET,    3,   32'h0);
        push_req(olt_pkg::FN_LOCATE, 0,   32'h55AA_55AA);
        drain();

        // Zero capacity refuses every insert; a write to an unmapped index
        // must leave the capacity alone.
        reg_write(olt_pkg::REG_CAPACITY, 32'd0);
        reg_write(olt_pkg::REG_CAPACITY + 1, 32'hFFFF_FFFF);
        push_req(olt_pkg::FN_INSERT, 4,   32'h2);
        push_req(olt_pkg::FN_DELETE, 2,   32'h0);
        drain();

        // Fill to the full store and bounce off it.
        reg_write(olt_pkg::REG_CAPACITY, 32'd64);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        random_phase(350, 60, 20);
        drain();

        // Capacity above the store depth is clamped to it.
        reg_write(olt_pkg::REG_CAPACITY, 32'd127);
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        random_phase(150, 55, 25);
        drain();

        // Lowered well below the current length, then drained under it.
        reg_write(olt_pkg::REG_CAPACITY, 32'd10);
        src_idle  = 1'b1;
        sink_idle = 1'b0;
        random_phase(200, 30, 40);
        drain();

        reg_write(olt_pkg::REG_CAPACITY, 32'd1);
        src_idle  = 1'b0;
        sink_idle = 1'b1;
        random_phase(100, 40, 30);
        drain();

        reg_write(olt_pkg::REG_CAPACITY, 32'd0);
        random_phase(80, 40, 30);
        drain();

        // Random capacity with a long hold-off on the result side.
        reg_write(olt_pkg::REG_CAPACITY, 32'($urandom_range(2, 63)));
        src_idle     = 1'b0;
        sink_idle    = 1'b1;
        hold_request = 1'b1;
        random_phase(250, 45, 25);
        drain();

        reg_write(olt_pkg::REG_CAPACITY, 32'd64);
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        random_phase(320, 50, 25);
        drain();

        if (expected_resps.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_resps.size());
            errors++;
        end
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
